FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies; define ASSERT_OFF to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/stb_pkg.sv
// shared types and constants of the soft timer bank
// no dependencies
package stb_pkg;

  localparam int TIMER_COUNT = 5;
  localparam int TMR_IDX_W   = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int IN_IDX_W    = 3;
  localparam int CNT_W       = 32;
  localparam int MASK_W      = 5;
  localparam int FUNC_W      = 2;
  localparam logic [CNT_W-1:0] TICK_STEP = CNT_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK  = 2'd0,
    FN_START = 2'd1,
    FN_STOP  = 2'd2,
    FN_READ  = 2'd3
  } stb_func_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             hit;
  } stb_dec_t;

endpackage

FILE: rtl/stb_dec_unit.sv
// shared saturating down-count unit, one timer per cycle
// depends on stb_pkg
module stb_dec_unit (
  input  logic [stb_pkg::CNT_W-1:0] cnt_in,
  input  logic                      enabled,
  output stb_pkg::stb_dec_t         dec
);

  always_comb begin
    dec.count = cnt_in;
    dec.hit   = 1'b0;
    if (enabled) begin
      if (cnt_in >= stb_pkg::TICK_STEP) begin
        dec.count = cnt_in - stb_pkg::TICK_STEP;
        dec.hit   = (cnt_in == stb_pkg::TICK_STEP);
      end else if (cnt_in != '0) begin
        dec.count = '0;
        dec.hit   = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/soft_timer_bank_top.sv
// soft timer bank top level: sequencer, timer state and result register
// depends on stb_pkg, stb_dec_unit and assert_macros.svh
//
// usage:
//   input channel in_valid/in_ready carries one operation per transaction:
//   tick, start, stop or read, with a timer index and a load count.
//   output channel out_valid/out_ready returns one result per operation.
//   cfg_wr_en/cfg_wr_data writes the notify mask; user must do so while idle (not enforced).
// timing:
//   start, stop and read pass from acceptance through S_DONE to the output
//   register (out_valid). tick walks the timers through one shared decrement
//   unit, one timer per cycle in S_TICK, then goes through S_DONE likewise.
//   in_ready is high only while the sequencer is idle; the next transaction
//   is taken the cycle after the previous result moves to the output register.
// reset:
//   rst_n low clears all counts, enables, the notify mask and out_valid.
// stall:
//   a held result stays in the output register; a finished result waits in
//   the sequencer until the output register frees, and in_ready stays low.
`include "assert_macros.svh"

module soft_timer_bank_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [stb_pkg::MASK_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [stb_pkg::FUNC_W-1:0]   in_func,
  input  logic [stb_pkg::IN_IDX_W-1:0] in_timer_index,
  input  logic [stb_pkg::CNT_W-1:0]    in_load_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stb_pkg::MASK_W-1:0]   out_expired_mask,
  output logic [stb_pkg::CNT_W-1:0]    out_count_value,
  output logic                         out_run_out
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [stb_pkg::TMR_IDX_W-1:0]   idx_r, idx_nxt;
  logic [stb_pkg::CNT_W-1:0]       count_r [stb_pkg::TIMER_COUNT];
  logic [stb_pkg::TIMER_COUNT-1:0] en_r;
  logic [stb_pkg::MASK_W-1:0]      notify_r;
  logic [stb_pkg::MASK_W-1:0]      res_mask_r, res_mask_nxt;
  logic [stb_pkg::CNT_W-1:0]       res_count_r, res_count_nxt;
  logic                            res_ro_r, res_ro_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [stb_pkg::MASK_W-1:0]      out_mask_r, out_mask_nxt;
  logic [stb_pkg::CNT_W-1:0]       out_count_r, out_count_nxt;
  logic                            out_ro_r, out_ro_nxt;

  logic [stb_pkg::TMR_IDX_W-1:0]   rd_addr;
  logic [stb_pkg::CNT_W-1:0]       rd_cnt;
  logic                            rd_en;
  logic                            in_rng;
  logic                            in_fire;
  logic                            cnt_we;
  logic [stb_pkg::CNT_W-1:0]       cnt_wdata;
  logic                            en_we;
  logic                            en_wdata;
  logic [stb_pkg::MASK_W-1:0]      notify_sh;
  stb_pkg::stb_dec_t               dec;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_rng    = (32'(in_timer_index) < stb_pkg::TIMER_COUNT);
  assign rd_addr   = (state_r == S_IDLE) ? stb_pkg::TMR_IDX_W'(in_timer_index) : idx_r;
  assign rd_cnt    = count_r[rd_addr];
  assign rd_en     = en_r[rd_addr];
  assign notify_sh = notify_r >> idx_r;

  stb_dec_unit u_dec (
    .cnt_in  (rd_cnt),
    .enabled (rd_en),
    .dec     (dec)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    res_mask_nxt  = res_mask_r;
    res_count_nxt = res_count_r;
    res_ro_nxt    = res_ro_r;
    out_valid_nxt = out_valid_r;
    out_mask_nxt  = out_mask_r;
    out_count_nxt = out_count_r;
    out_ro_nxt    = out_ro_r;
    cnt_we        = 1'b0;
    cnt_wdata     = dec.count;
    en_we         = 1'b0;
    en_wdata      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_mask_nxt  = '0;
          res_count_nxt = '0;
          res_ro_nxt    = 1'b0;
          state_nxt     = S_DONE;
          case (stb_pkg::stb_func_t'(in_func))
            stb_pkg::FN_TICK: begin
              idx_nxt   = '0;
              state_nxt = S_TICK;
            end
            stb_pkg::FN_START: begin
              if (in_rng) begin
                cnt_we    = (in_load_count != '0);
                cnt_wdata = in_load_count;
                en_we     = 1'b1;
                en_wdata  = 1'b1;
              end
            end
            stb_pkg::FN_STOP: begin
              if (in_rng) begin
                en_we    = 1'b1;
                en_wdata = 1'b0;
              end
            end
            stb_pkg::FN_READ: begin
              if (in_rng) begin
                res_count_nxt = rd_cnt;
                res_ro_nxt    = (rd_cnt == '0);
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_TICK: begin
        cnt_we    = 1'b1;
        cnt_wdata = dec.count;
        if (dec.hit && notify_sh[0]) begin
          res_mask_nxt = res_mask_r | (stb_pkg::MASK_W'(1) << idx_r);
        end
        if (idx_r == stb_pkg::TMR_IDX_W'(stb_pkg::TIMER_COUNT - 1)) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = res_mask_r;
          out_count_nxt = res_count_r;
          out_ro_nxt    = res_ro_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      notify_r    <= '0;
      en_r        <= '0;
      for (int i = 0; i < stb_pkg::TIMER_COUNT; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        notify_r <= cfg_wr_data;
      end
      if (cnt_we) begin
        count_r[rd_addr] <= cnt_wdata;
      end
      if (en_we) begin
        en_r[rd_addr] <= en_wdata;
      end
    end
    res_mask_r  <= res_mask_nxt;
    res_count_r <= res_count_nxt;
    res_ro_r    <= res_ro_nxt;
    out_mask_r  <= out_mask_nxt;
    out_count_r <= out_count_nxt;
    out_ro_r    <= out_ro_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_expired_mask = out_mask_r;
  assign out_count_value  = out_count_r;
  assign out_run_out      = out_ro_r;

  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_fire, !in_ready)
  `ASSERT_IMPL(a_tick_blocks_input, clk, rst_n, state_r == S_TICK, !in_ready)
  `ASSERT_IMPL(a_run_out_zero, clk, rst_n, out_valid_r && out_ro_r, out_count_r == '0)
  `ASSERT_IMPL(a_mask_only_tick, clk, rst_n, out_valid_r && (out_mask_r != '0),
               (out_count_r == '0) && !out_ro_r)

endmodule
